### src/ffa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit unit allocator package
// Field widths, request codes, shared request/result types and sequencer
// states used by the allocator's modules.
// ----------------------------------------------------------------------------
package ffa_pkg;

    // Field widths of the request and result items
    localparam int SIZE_W      = 11;
    localparam int OWNER_W     = 10;
    localparam int START_W     = 10;
    localparam int FREED_W     = 11;
    localparam int CFG_W       = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Active unit count after reset
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 11'd1024;

    // Request kinds
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [SIZE_W-1:0]  request_size;
        logic [OWNER_W-1:0] owner_id;
    } t_ffa_item;

    typedef struct packed {
        logic               granted;
        logic [START_W-1:0] start_unit;
        logic [FREED_W-1:0] units_freed;
    } t_ffa_result;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_SCAN,
        S_ALLOC_FILL,
        S_FREE_SCAN,
        S_DONE
    } t_ffa_state;

endpackage

### src/ffa_owner_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Owner map memory
// One entry per unit holding 0 for a free unit or the owning id. One write
// port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ffa_owner_mem #(
    parameter int MEM_UNITS  = 1024,
    parameter int OWNER_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(MEM_UNITS)-1:0]  i_waddr,
    input  logic [OWNER_BITS-1:0]         i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(MEM_UNITS)-1:0]  i_raddr,
    output logic [OWNER_BITS-1:0]         o_rdata
);

    logic [OWNER_BITS-1:0] r_mem [MEM_UNITS];
    logic [OWNER_BITS-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/ffa_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator scan sequencer
// Walks the owner map one unit a cycle: clears it after reset, searches for
// the first free run long enough for an allocate and tags it, or releases
// every unit of an owner on a free. Holds the result until it is taken.
// ----------------------------------------------------------------------------
module ffa_scan #(
    parameter int MEM_UNITS  = 1024,
    parameter int OWNER_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ffa_pkg::CFG_W-1:0]     i_active_units,
    input  logic                          i_start,
    input  ffa_pkg::t_ffa_item            i_item,
    output logic                          o_ready,
    output logic                          o_res_valid,
    input  logic                          i_res_take,
    output ffa_pkg::t_ffa_result          o_res,
    output logic                          o_mem_we,
    output logic [$clog2(MEM_UNITS)-1:0]  o_mem_waddr,
    output logic [OWNER_BITS-1:0]         o_mem_wdata,
    output logic                          o_mem_re,
    output logic [$clog2(MEM_UNITS)-1:0]  o_mem_raddr,
    input  logic [OWNER_BITS-1:0]         i_mem_rdata
);

    import ffa_pkg::*;

    localparam int AW = $clog2(MEM_UNITS);
    localparam int CW = $clog2(MEM_UNITS + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;

    t_ffa_state            r_state, n_state;
    logic [CW-1:0]         r_addr, n_addr;
    logic                  r_pend, n_pend;
    logic [AW-1:0]         r_pend_unit, n_pend_unit;
    logic [AW-1:0]         r_run_start, n_run_start;
    logic [CW-1:0]         r_run_len, n_run_len;
    logic [CW-1:0]         r_left, n_left;
    logic [CW-1:0]         r_freed, n_freed;
    logic [SIZE_W-1:0]     r_size, n_size;
    logic [OWNER_BITS-1:0] r_owner, n_owner;
    t_ffa_result           r_res, n_res;

    logic [LW-1:0]         w_act_ext;
    logic [CW-1:0]         w_limit;
    logic [OWNER_BITS-1:0] w_owner_in;
    logic [CW-1:0]         w_len_inc;
    logic [AW-1:0]         w_cand_start;
    logic                  w_issue;

    // Usable units: active count saturated at the memory size
    assign w_act_ext = LW'(i_active_units);
    assign w_limit   = (w_act_ext > LW'(MEM_UNITS)) ? CW'(MEM_UNITS) : w_act_ext[CW-1:0];

    // Owner id narrowed or widened to the stored width
    assign w_owner_in = OWNER_BITS'(i_item.owner_id);

    assign w_len_inc    = r_run_len + CW'(1);
    assign w_cand_start = (r_run_len == '0) ? r_pend_unit : r_run_start;

    // State and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_unit <= n_pend_unit;
        r_run_start <= n_run_start;
        r_run_len   <= n_run_len;
        r_left      <= n_left;
        r_freed     <= n_freed;
        r_size      <= n_size;
        r_owner     <= n_owner;
        r_res       <= n_res;
    end

    // Next state, memory accesses and handshake outputs
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_pend      = 1'b0;
        n_pend_unit = r_pend_unit;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        n_left      = r_left;
        n_freed     = r_freed;
        n_size      = r_size;
        n_owner     = r_owner;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_addr[AW-1:0];
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_addr[AW-1:0];
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        w_issue     = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                // Sweep the map to free, one unit a cycle
                o_mem_we = 1'b1;
                n_addr   = r_addr + CW'(1);
                if (r_addr == CW'(MEM_UNITS - 1)) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                end
            end

            S_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_size      = i_item.request_size;
                    n_owner     = w_owner_in;
                    n_addr      = '0;
                    n_run_len   = '0;
                    n_run_start = '0;
                    n_freed     = '0;
                    n_res       = '0;
                    if (i_item.mode == MODE_FREE) begin
                        n_state = (w_owner_in == '0) ? S_DONE : S_FREE_SCAN;
                    end else if (w_owner_in == '0 || i_item.request_size == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ALLOC_SCAN;
                    end
                end
            end

            S_ALLOC_SCAN: begin
                // Issue the next read while the previous unit is judged
                w_issue     = (r_addr < w_limit);
                o_mem_re    = w_issue;
                n_pend      = w_issue;
                n_pend_unit = r_addr[AW-1:0];
                if (w_issue) begin
                    n_addr = r_addr + CW'(1);
                end
                if (r_pend) begin
                    if (i_mem_rdata == '0) begin
                        n_run_start = w_cand_start;
                        n_run_len   = w_len_inc;
                        if (LW'(w_len_inc) >= LW'(r_size)) begin
                            // Run long enough: tag it from its start
                            n_state = S_ALLOC_FILL;
                            n_pend  = 1'b0;
                            n_addr  = CW'(w_cand_start);
                            n_left  = w_len_inc;
                        end
                    end else begin
                        n_run_len = '0;
                    end
                end else if (!w_issue) begin
                    // No unit left to read: allocate fails
                    n_state = S_DONE;
                end
            end

            S_ALLOC_FILL: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = r_owner;
                n_addr      = r_addr + CW'(1);
                n_left      = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state           = S_DONE;
                    n_res.granted     = 1'b1;
                    n_res.start_unit  = START_W'(r_run_start);
                    n_res.units_freed = '0;
                end
            end

            S_FREE_SCAN: begin
                w_issue     = (r_addr != CW'(MEM_UNITS));
                o_mem_re    = w_issue;
                n_pend      = w_issue;
                n_pend_unit = r_addr[AW-1:0];
                if (w_issue) begin
                    n_addr = r_addr + CW'(1);
                end
                if (r_pend && i_mem_rdata == r_owner) begin
                    // Release the unit just read
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_pend_unit;
                    n_freed     = r_freed + CW'(1);
                end
                if (!r_pend && !w_issue) begin
                    n_state           = S_DONE;
                    n_res.granted     = 1'b0;
                    n_res.start_unit  = '0;
                    n_res.units_freed = FREED_W'(r_freed);
                end
            end

            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

### src/first_fit_unit_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit unit allocator
// Keeps an owner map of equal memory units. An allocate request tags the
// lowest-addressed free run that is long enough; a free request releases all
// units of an owner and reports how many were released.
//
//  Channel  Direction  Handshake                  Contents
//  s_axis   in         s_axis_tvalid/tready       request: size, owner; kind in tuser
//  m_axis   out        m_axis_tvalid/tready       result: granted, start, units freed
//  cfg      in         i_cfg_valid/o_cfg_ready    active unit count
//
// After reset a clearing pass frees the owner map, one unit a cycle, and no
// request is taken until it ends (cfg writes still are). An allocate searches
// up to the usable units for a long enough free run, then tags it one unit a
// cycle; a free walks all MEM_UNITS units. Both walk the single read port of
// the owner map one unit a cycle.
// A finished result waits in the output register while the next request runs.
// ----------------------------------------------------------------------------
module first_fit_unit_allocator_unit #(
    parameter int MEM_UNITS  = 1024,
    parameter int OWNER_BITS = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // cfg write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ffa_pkg::CFG_W-1:0]          i_cfg_data,    // active_units
    // request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ffa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // request_size, owner_id, pad
    input  logic                               s_axis_tuser,  // mode
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ffa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // granted, start_unit,
                                                              // units_freed, pad
);

    import ffa_pkg::*;

    localparam int AW = $clog2(MEM_UNITS);

    logic [CFG_W-1:0]      r_active_units;
    logic                  r_out_valid;
    t_ffa_result           r_out_res;

    t_ffa_item             w_item;
    t_ffa_result           w_res;
    logic                  w_res_valid;
    logic                  w_res_take;
    logic                  w_start;
    logic                  w_scan_ready;
    logic                  w_mem_we;
    logic [AW-1:0]         w_mem_waddr;
    logic [OWNER_BITS-1:0] w_mem_wdata;
    logic                  w_mem_re;
    logic [AW-1:0]         w_mem_raddr;
    logic [OWNER_BITS-1:0] w_mem_rdata;

    // Configuration register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_units <= ACTIVE_RESET;
        end else if (i_cfg_valid) begin
            r_active_units <= i_cfg_data;
        end
    end

    // Unpack the request
    assign w_item.mode         = s_axis_tuser;
    assign w_item.request_size = s_axis_tdata[SIZE_W-1:0];
    assign w_item.owner_id     = s_axis_tdata[SIZE_W+OWNER_W-1:SIZE_W];

    assign s_axis_tready = w_scan_ready;
    assign w_start       = s_axis_tvalid && w_scan_ready;

    ffa_scan #(
        .MEM_UNITS  (MEM_UNITS),
        .OWNER_BITS (OWNER_BITS)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_active_units (r_active_units),
        .i_start        (w_start),
        .i_item         (w_item),
        .o_ready        (w_scan_ready),
        .o_res_valid    (w_res_valid),
        .i_res_take     (w_res_take),
        .o_res          (w_res),
        .o_mem_we       (w_mem_we),
        .o_mem_waddr    (w_mem_waddr),
        .o_mem_wdata    (w_mem_wdata),
        .o_mem_re       (w_mem_re),
        .o_mem_raddr    (w_mem_raddr),
        .i_mem_rdata    (w_mem_rdata)
    );

    ffa_owner_mem #(
        .MEM_UNITS  (MEM_UNITS),
        .OWNER_BITS (OWNER_BITS)
    ) u_owner_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // Output register: take a result when the slot is empty or draining
    assign w_res_take = w_res_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_res.units_freed,
                                         r_out_res.start_unit,
                                         r_out_res.granted});

`ifndef NO_ASSERTIONS
    // The clearing pass blocks requests in the first cycle after reset
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("request taken during clearing pass");

    // One request at a time: acceptance closes the request side
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request side open while a request is in work");

    // A result never both grants and reports released units
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_res.granted && r_out_res.units_freed != '0))
        else $error("result mixes grant and release");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit unit allocator testbench
// Drives allocate and free requests through the request stream and tracks a
// private owner map that predicts every result. Each result is checked field
// by field in order. The active unit count is changed between phases, with
// the extremes among the values. The request side sends in bursts with
// random gaps and the result side stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module testbench;
    import ffa_pkg::*;

    localparam int MAP_UNITS  = 1024;
    localparam int POOL_SIZE  = 24;
    localparam int PHASE_ITEMS = 72;

    // Owner map mirror, active count and results still due from the block
    class allocation_tracker;
        logic [OWNER_W-1:0] owner_map [MAP_UNITS];
        int unsigned        usable;
        t_ffa_result        pending_results [$];
        int unsigned        mismatches;

        function new();
            foreach (owner_map[u]) owner_map[u] = '0;
            usable     = MAP_UNITS;
            mismatches = 0;
        endfunction

        function void set_active(logic [CFG_W-1:0] value);
            usable = (value > MAP_UNITS) ? MAP_UNITS : value;
        endfunction

        // Apply an accepted request to the map and queue the result it causes
        function void note_request(t_ffa_item req);
            t_ffa_result res;
            int unsigned run_start, run_len, u, released;
            bit          found;
            res       = '0;
            run_start = 0;
            run_len   = 0;
            released  = 0;
            found     = 1'b0;
            if (req.mode == MODE_ALLOC) begin
                if (req.request_size != 0 && req.owner_id != 0) begin
                    // first free run long enough, below the active count only
                    for (u = 0; u < usable && !found; u++) begin
                        if (owner_map[u] == 0) begin
                            if (run_len == 0) run_start = u;
                            run_len++;
                            if (run_len >= req.request_size) found = 1'b1;
                        end else begin
                            run_len = 0;
                        end
                    end
                    if (found) begin
                        for (u = run_start; u < run_start + req.request_size; u++)
                            owner_map[u] = req.owner_id;
                        res.granted    = 1'b1;
                        res.start_unit = START_W'(run_start);
                    end
                end
            end else if (req.owner_id != 0) begin
                // release the owner across the whole map, active or not
                for (u = 0; u < MAP_UNITS; u++) begin
                    if (owner_map[u] == req.owner_id) begin
                        owner_map[u] = '0;
                        released++;
                    end
                end
                res.units_freed = FREED_W'(released);
            end
            pending_results.insert(pending_results.size(), res);
        endfunction

        function void check_result(t_ffa_result got);
            t_ffa_result exp;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none due: granted %0d start %0d freed %0d",
                         $time, got.granted, got.start_unit, got.units_freed);
                mismatches++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.granted !== exp.granted) begin
                $display("%0t: granted expected %0d actual %0d",
                         $time, exp.granted, got.granted);
                mismatches++;
            end
            if (got.start_unit !== exp.start_unit) begin
                $display("%0t: start_unit expected %0d actual %0d",
                         $time, exp.start_unit, got.start_unit);
                mismatches++;
            end
            if (got.units_freed !== exp.units_freed) begin
                $display("%0t: units_freed expected %0d actual %0d",
                         $time, exp.units_freed, got.units_freed);
                mismatches++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    allocation_tracker  tracker = new();
    int unsigned        burst_left = 0;
    int unsigned        ready_phase = 0;
    logic [15:0]        ready_pattern = 16'hFFFF;
    logic [OWNER_W-1:0] owner_pool [POOL_SIZE];

    first_fit_unit_allocator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Stall the result side on a rotating pattern, reloaded now and then
    always @(posedge i_clk) begin
        if (ready_phase == 0) begin
            ready_phase = $urandom_range(300, 40);
            case ($urandom_range(2, 0))
                0:       ready_pattern = 16'hFFFF;
                1:       ready_pattern = 16'($urandom);
                default: ready_pattern = 16'($urandom | $urandom);
            endcase
        end
        ready_phase--;
        ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
        m_axis_tready <= ready_pattern[0];
    end

    // Check every accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_ffa_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.granted     = m_axis_tdata[0];
            got.start_unit  = m_axis_tdata[START_W:1];
            got.units_freed = m_axis_tdata[START_W+FREED_W:START_W+1];
            tracker.check_result(got);
        end
    end

    // Send one request, opening a new burst after a random gap when due
    task automatic issue(input logic mode, input logic [SIZE_W-1:0] size,
                         input logic [OWNER_W-1:0] owner);
        t_ffa_item   req;
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            gap = ($urandom_range(5, 0) == 0) ? $urandom_range(40, 1) : $urandom_range(4, 0);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req.mode         = mode;
        req.request_size = size;
        req.owner_id     = owner;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {3'b000, owner, size};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        tracker.note_request(req);
    endtask

    // Hold off the request side until every due result has come back
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_active(input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        tracker.set_active(value);
    endtask

    // Mostly well-formed allocate and free traffic over a pool of owners
    task automatic random_request();
        int unsigned span, pick;
        span = (tracker.usable == 0) ? 1 : tracker.usable;
        pick = $urandom_range(99, 0);
        if (pick < 55) begin
            if ($urandom_range(9, 0) < 8)
                issue(MODE_ALLOC, SIZE_W'($urandom_range((span + 7) / 8, 1)),
                      owner_pool[$urandom_range(POOL_SIZE - 1, 0)]);
            else
                issue(MODE_ALLOC, SIZE_W'($urandom_range(span, 1)),
                      owner_pool[$urandom_range(POOL_SIZE - 1, 0)]);
        end else if (pick < 85) begin
            issue(MODE_FREE, SIZE_W'($urandom_range(2047, 0)),
                  owner_pool[$urandom_range(POOL_SIZE - 1, 0)]);
        end else begin
            case ($urandom_range(4, 0))
                0: issue(MODE_ALLOC, '0, owner_pool[$urandom_range(POOL_SIZE - 1, 0)]);
                1: issue(MODE_ALLOC, SIZE_W'($urandom_range(span, 1)), '0);
                2: issue(MODE_ALLOC, SIZE_W'($urandom_range(2047, 0)),
                         OWNER_W'($urandom_range(1023, 0)));
                3: issue(MODE_FREE, SIZE_W'($urandom_range(2047, 0)),
                         OWNER_W'($urandom_range(1023, 0)));
                default: issue(MODE_FREE, SIZE_W'($urandom_range(2047, 0)), '0);
            endcase
        end
    endtask

    initial begin
        logic [CFG_W-1:0] active_plan [8];
        int unsigned      phase, n;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= 1'b0;
        s_axis_tdata  <= '0;
        for (n = 0; n < 16; n++) owner_pool[n] = OWNER_W'(n + 1);
        owner_pool[16] = 10'd1023;
        owner_pool[17] = 10'd512;
        for (n = 18; n < POOL_SIZE; n++) owner_pool[n] = OWNER_W'($urandom_range(1022, 17));
        active_plan = '{11'd2047, 11'd64, 11'd0, 11'd1, 11'd1024, 11'd300,
                        CFG_W'($urandom_range(1024, 1)), 11'd16};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_active(11'd1024);

        // Directed: field extremes, refused requests, holes and joined runs
        issue(MODE_ALLOC, 11'd1, 10'd1);
        issue(MODE_ALLOC, 11'd0, 10'd2);
        issue(MODE_ALLOC, 11'd5, 10'd0);
        issue(MODE_ALLOC, 11'd2047, 10'd3);
        issue(MODE_ALLOC, 11'd1024, 10'd2);
        issue(MODE_FREE, 11'd0, 10'd1);
        issue(MODE_ALLOC, 11'd1024, 10'd1023);
        issue(MODE_ALLOC, 11'd1, 10'd4);
        issue(MODE_FREE, 11'd2047, 10'd0);
        issue(MODE_FREE, 11'd0, 10'd77);
        issue(MODE_FREE, 11'd0, 10'd1023);
        issue(MODE_ALLOC, 11'd3, 10'd3);
        issue(MODE_ALLOC, 11'd4, 10'd4);
        issue(MODE_ALLOC, 11'd5, 10'd5);
        issue(MODE_FREE, 11'd0, 10'd4);
        issue(MODE_ALLOC, 11'd2, 10'd6);
        issue(MODE_ALLOC, 11'd3, 10'd7);
        issue(MODE_FREE, 11'd0, 10'd3);
        issue(MODE_FREE, 11'd0, 10'd6);
        issue(MODE_ALLOC, 11'd7, 10'd8);
        issue(MODE_FREE, 11'd0, 10'd5);
        issue(MODE_FREE, 11'd0, 10'd7);
        issue(MODE_FREE, 11'd2047, 10'd8);
        issue(MODE_ALLOC, 11'd1023, 10'd512);
        issue(MODE_FREE, 11'd1365, 10'd512);

        // Random phases, each under its own active unit count
        for (phase = 0; phase < 8; phase++) begin
            hold_until_drained();
            write_active(active_plan[phase]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                random_request();
                if ($urandom_range(39, 0) == 0) hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (60) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Give up well beyond the slowest correct run
    initial begin
        #(40_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
